@@ src/dda_line_rasterizer_top_assert.svh @@
// Assertion macros shared by the checker of the line rasterizer.
`ifndef DDA_LINE_RASTERIZER_TOP_ASSERT_SVH
`define DDA_LINE_RASTERIZER_TOP_ASSERT_SVH
// Implication in the same cycle, disabled during reset.
`define DDA_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication into the next cycle, disabled during reset.
`define DDA_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

@@ src/dda_pkg.sv @@
// Package with widths, codes and control structs of the line rasterizer.
`default_nettype none
package dda_pkg;
  localparam int COORD_BITS = 16;
  localparam int FRAC_BITS = 16;
  localparam int CW = COORD_BITS;
  localparam int CNT_W = CW + 1;
  localparam int RAD_W = 2 * CW + 2;
  localparam int REM_W = CW + 3;
  localparam int NUM_W = CW + FRAC_BITS;
  localparam int STEP_W = FRAC_BITS + 2;
  localparam int POS_W = CW + FRAC_BITS + 4;
  localparam int PX_W = POS_W - FRAC_BITS;
  localparam int ROOT_ITERS = RAD_W / 2;
  localparam int DIV_ITERS = NUM_W;
  localparam int ITER_W = $clog2(DIV_ITERS + 1);
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_BPP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_CLAMP = 3'd4;

  localparam logic CMD_START = 1'b0;
  localparam logic CMD_STEP = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
    logic sq_x;
    logic sq_y;
    logic root_it;
    logic div_it;
    logic finish;
  } dda_cmd_t;

  typedef struct packed {
    logic degenerate;
    logic active;
    logic out_busy;
  } dda_sts_t;
endpackage
`default_nettype wire

@@ src/dda_cmd_if.sv @@
// Interface of the command item channel.
`default_nettype none
interface dda_cmd_if;
  logic valid;
  logic ready;
  logic command;
  logic signed [dda_pkg::CW-1:0] begin_x;
  logic signed [dda_pkg::CW-1:0] begin_y;
  logic signed [dda_pkg::CW-1:0] end_x;
  logic signed [dda_pkg::CW-1:0] end_y;
  logic [31:0] line_color;
  modport source(output valid, command, begin_x, begin_y, end_x, end_y, line_color,
                 input ready);
  modport sink(input valid, command, begin_x, begin_y, end_x, end_y, line_color,
               output ready);
endinterface
`default_nettype wire

@@ src/dda_pix_if.sv @@
// Interface of the pixel item channel.
`default_nettype none
interface dda_pix_if;
  logic valid;
  logic ready;
  logic signed [dda_pkg::CW-1:0] pixel_x;
  logic signed [dda_pkg::CW-1:0] pixel_y;
  logic visible;
  logic [31:0] byte_offset;
  logic [31:0] pixel_color;
  logic last;
  modport source(output valid, pixel_x, pixel_y, visible, byte_offset, pixel_color, last,
                 input ready);
  modport sink(input valid, pixel_x, pixel_y, visible, byte_offset, pixel_color, last,
               output ready);
endinterface
`default_nettype wire

@@ src/dda_line_rasterizer_top.sv @@
// Top level of the line rasterizer: controller, datapath and channel wiring.
// A step item is taken every cycle while a line is active and the pixel output register is
// free or being emptied, giving one pixel per cycle. A start item occupies the block while it forms
// the squared length on one shared multiplier, then runs the bit-pair square root and then the
// two bit-serial dividers that form the per-axis steps; a start whose endpoints coincide
// returns at once. A step with no active line is taken and dropped.
`default_nettype none
module dda_line_rasterizer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_we_i,
  input  wire logic [dda_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  wire logic [dda_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  dda_cmd_if.sink                             cmd_i,
  dda_pix_if.source                           pix_o
);
  dda_pkg::dda_cmd_t cmd;
  dda_pkg::dda_sts_t sts;

  dda_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (cmd_i.valid),
    .in_command_i(cmd_i.command),
    .in_ready_o  (cmd_i.ready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  dda_dp u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .begin_x_i    (cmd_i.begin_x),
    .begin_y_i    (cmd_i.begin_y),
    .end_x_i      (cmd_i.end_x),
    .end_y_i      (cmd_i.end_y),
    .line_color_i (cmd_i.line_color),
    .out_ready_i  (pix_o.ready),
    .out_valid_o  (pix_o.valid),
    .pixel_x_o    (pix_o.pixel_x),
    .pixel_y_o    (pix_o.pixel_y),
    .visible_o    (pix_o.visible),
    .byte_offset_o(pix_o.byte_offset),
    .pixel_color_o(pix_o.pixel_color),
    .last_o       (pix_o.last),
    .cmd_i        (cmd),
    .sts_o        (sts)
  );
endmodule
`default_nettype wire

@@ src/dda_ctrl.sv @@
// Controller state machine that sequences line setup and pixel steps.
`default_nettype none
module dda_ctrl (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             in_valid_i,
  input  wire logic             in_command_i,
  output logic                  in_ready_o,
  input  dda_pkg::dda_sts_t     sts_i,
  output dda_pkg::dda_cmd_t     cmd_o
);
  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_SQX  = 5'b00010,
    ST_SQY  = 5'b00100,
    ST_ROOT = 5'b01000,
    ST_DIV  = 5'b10000
  } state_e;

  state_e state_q, state_d;
  logic [dda_pkg::ITER_W-1:0] cnt_q, cnt_d;
  logic fire;
  logic root_last, div_last;

  assign in_ready_o = (state_q == ST_IDLE) && !sts_i.out_busy;
  assign fire = in_valid_i && in_ready_o;
  assign root_last = cnt_q == dda_pkg::ITER_W'(dda_pkg::ROOT_ITERS - 1);
  assign div_last = cnt_q == dda_pkg::ITER_W'(dda_pkg::DIV_ITERS - 1);

  always_comb begin
    state_d = state_q;
    cnt_d = cnt_q;
    cmd_o = '0;
    case (state_q)
      ST_IDLE: begin
        cmd_o.load = fire && (in_command_i == dda_pkg::CMD_START);
        cmd_o.step = fire && (in_command_i == dda_pkg::CMD_STEP) && sts_i.active;
        if (cmd_o.load && !sts_i.degenerate) begin
          state_d = ST_SQX;
        end
      end
      ST_SQX: begin
        cmd_o.sq_x = 1'b1;
        state_d = ST_SQY;
      end
      ST_SQY: begin
        cmd_o.sq_y = 1'b1;
        cnt_d = '0;
        state_d = ST_ROOT;
      end
      ST_ROOT: begin
        cmd_o.root_it = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (root_last) begin
          cnt_d = '0;
          state_d = ST_DIV;
        end
      end
      ST_DIV: begin
        cmd_o.div_it = 1'b1;
        cnt_d = cnt_q + 1'b1;
        if (div_last) begin
          cmd_o.finish = 1'b1;
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q <= '0;
    end else begin
      state_q <= state_d;
      cnt_q <= cnt_d;
    end
  end
endmodule
`default_nettype wire

@@ src/dda_dp.sv @@
// Datapath with setup root and dividers, position walk and pixel output register.
`default_nettype none
module dda_dp (
  input  wire logic                              clk_i,
  input  wire logic                              rst_ni,
  input  wire logic                              cfg_we_i,
  input  wire logic [dda_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  wire logic [dda_pkg::CFG_DATA_W-1:0]    cfg_wdata_i,
  input  wire logic signed [dda_pkg::CW-1:0]     begin_x_i,
  input  wire logic signed [dda_pkg::CW-1:0]     begin_y_i,
  input  wire logic signed [dda_pkg::CW-1:0]     end_x_i,
  input  wire logic signed [dda_pkg::CW-1:0]     end_y_i,
  input  wire logic [31:0]                       line_color_i,
  input  wire logic                              out_ready_i,
  output logic                                   out_valid_o,
  output logic signed [dda_pkg::CW-1:0]          pixel_x_o,
  output logic signed [dda_pkg::CW-1:0]          pixel_y_o,
  output logic                                   visible_o,
  output logic [31:0]                            byte_offset_o,
  output logic [31:0]                            pixel_color_o,
  output logic                                   last_o,
  input  dda_pkg::dda_cmd_t                      cmd_i,
  output dda_pkg::dda_sts_t                      sts_o
);
  localparam int CW = dda_pkg::CW;
  localparam int FB = dda_pkg::FRAC_BITS;

  logic [14:0] width_q, height_q;
  logic [15:0] pitch_q;
  logic [5:0] bpp_q;
  logic clamp_q;

  logic signed [CW-1:0] bx, by, ex, ey;
  logic signed [CW:0] dx, dy;
  logic [CW-1:0] absx_q, absy_q;
  logic negx_q, negy_q;
  logic [31:0] color_q;
  logic [dda_pkg::RAD_W-1:0] rad_q;
  logic [dda_pkg::REM_W-1:0] rem_q;
  logic [dda_pkg::CNT_W-1:0] root_q;
  logic [dda_pkg::NUM_W-1:0] numx_q, numy_q;
  logic [dda_pkg::CNT_W-1:0] remx_q, remy_q;
  logic signed [dda_pkg::POS_W-1:0] pos_x_q, pos_y_q;
  logic signed [dda_pkg::STEP_W-1:0] step_x_q, step_y_q;
  logic [dda_pkg::CNT_W-1:0] left_q;
  logic active_q;
  logic out_valid_q;

  logic [CW-1:0] sq_op;
  logic [2*CW-1:0] sq;
  logic [dda_pkg::REM_W+1:0] rem_ext, trial;
  logic root_ge;
  logic [dda_pkg::CNT_W:0] rx, ry;
  logic gex, gey;
  logic signed [dda_pkg::PX_W-1:0] px, py;
  logic vis;
  logic [CW-1:0] pxu, pyu;

  function automatic logic signed [CW-1:0] clamp_to(logic signed [CW-1:0] v,
                                                     logic [14:0] hi);
    logic signed [CW+15:0] ve;
    logic signed [CW+15:0] he;
    ve = (CW+16)'(v);
    he = $signed((CW+16)'(hi));
    if (v < 0) return '0;
    if (ve > he) return CW'(he);
    return v;
  endfunction

  always_comb begin
    bx = clamp_q ? clamp_to(begin_x_i, width_q) : begin_x_i;
    by = clamp_q ? clamp_to(begin_y_i, height_q) : begin_y_i;
    ex = clamp_q ? clamp_to(end_x_i, width_q) : end_x_i;
    ey = clamp_q ? clamp_to(end_y_i, height_q) : end_y_i;
    dx = (CW+1)'(ex) - (CW+1)'(bx);
    dy = (CW+1)'(ey) - (CW+1)'(by);
  end

  assign sts_o.degenerate = (bx == ex) && (by == ey);
  assign sts_o.active = active_q;
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  assign sq_op = cmd_i.sq_x ? absx_q : absy_q;
  assign sq = sq_op * sq_op;

  assign rem_ext = {rem_q, rad_q[dda_pkg::RAD_W-1 -: 2]};
  assign trial = (dda_pkg::REM_W+2)'({root_q, 2'b01});
  assign root_ge = rem_ext >= trial;

  assign rx = {remx_q, numx_q[dda_pkg::NUM_W-1]};
  assign ry = {remy_q, numy_q[dda_pkg::NUM_W-1]};
  assign gex = rx >= {1'b0, root_q};
  assign gey = ry >= {1'b0, root_q};

  always_comb begin
    px = dda_pkg::PX_W'(pos_x_q >>> FB);
    py = dda_pkg::PX_W'(pos_y_q >>> FB);
    if (pos_x_q[dda_pkg::POS_W-1] && (pos_x_q[FB-1:0] != '0)) px = px + 1'b1;
    if (pos_y_q[dda_pkg::POS_W-1] && (pos_y_q[FB-1:0] != '0)) py = py + 1'b1;
    vis = !px[dda_pkg::PX_W-1] && !py[dda_pkg::PX_W-1]
          && (px <= $signed(dda_pkg::PX_W'(width_q)))
          && (py <= $signed(dda_pkg::PX_W'(height_q)));
    pxu = CW'(px);
    pyu = CW'(py);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q <= 15'd1920;
      height_q <= 15'd1080;
      pitch_q <= 16'd7680;
      bpp_q <= 6'd32;
      clamp_q <= 1'b0;
      active_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_idx_i)
          dda_pkg::CFG_WIDTH: width_q <= cfg_wdata_i[14:0];
          dda_pkg::CFG_HEIGHT: height_q <= cfg_wdata_i[14:0];
          dda_pkg::CFG_PITCH: pitch_q <= cfg_wdata_i;
          dda_pkg::CFG_BPP: bpp_q <= cfg_wdata_i[5:0];
          dda_pkg::CFG_CLAMP: clamp_q <= cfg_wdata_i[0];
          default: ;
        endcase
      end
      if (cmd_i.load) begin
        active_q <= 1'b0;
      end else if (cmd_i.finish) begin
        active_q <= 1'b1;
      end else if (cmd_i.step) begin
        active_q <= left_q != dda_pkg::CNT_W'(1);
      end
      if (cmd_i.step) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      color_q <= line_color_i;
      absx_q <= CW'(dx[CW] ? -dx : dx);
      absy_q <= CW'(dy[CW] ? -dy : dy);
      negx_q <= dx[CW];
      negy_q <= dy[CW];
      pos_x_q <= dda_pkg::POS_W'(bx) <<< FB;
      pos_y_q <= dda_pkg::POS_W'(by) <<< FB;
    end
    if (cmd_i.sq_x) begin
      rad_q <= dda_pkg::RAD_W'(sq);
      rem_q <= '0;
      root_q <= '0;
    end
    if (cmd_i.sq_y) begin
      rad_q <= rad_q + dda_pkg::RAD_W'(sq);
      numx_q <= {absx_q, {FB{1'b0}}};
      numy_q <= {absy_q, {FB{1'b0}}};
      remx_q <= '0;
      remy_q <= '0;
    end
    if (cmd_i.root_it) begin
      rad_q <= rad_q << 2;
      rem_q <= dda_pkg::REM_W'(root_ge ? rem_ext - trial : rem_ext);
      root_q <= {root_q[dda_pkg::CNT_W-2:0], root_ge};
    end
    if (cmd_i.div_it) begin
      remx_q <= dda_pkg::CNT_W'(gex ? rx - {1'b0, root_q} : rx);
      remy_q <= dda_pkg::CNT_W'(gey ? ry - {1'b0, root_q} : ry);
      numx_q <= {numx_q[dda_pkg::NUM_W-2:0], gex};
      numy_q <= {numy_q[dda_pkg::NUM_W-2:0], gey};
    end
    if (cmd_i.finish) begin
      step_x_q <= negx_q ? -dda_pkg::STEP_W'({numx_q[dda_pkg::NUM_W-2:0], gex})
                         : dda_pkg::STEP_W'({numx_q[dda_pkg::NUM_W-2:0], gex});
      step_y_q <= negy_q ? -dda_pkg::STEP_W'({numy_q[dda_pkg::NUM_W-2:0], gey})
                         : dda_pkg::STEP_W'({numy_q[dda_pkg::NUM_W-2:0], gey});
      left_q <= root_q;
    end
    if (cmd_i.step) begin
      pos_x_q <= pos_x_q + dda_pkg::POS_W'(step_x_q);
      pos_y_q <= pos_y_q + dda_pkg::POS_W'(step_y_q);
      left_q <= left_q - 1'b1;
      pixel_x_o <= CW'(px);
      pixel_y_o <= CW'(py);
      visible_o <= vis;
      byte_offset_o <= vis ? 32'(pyu * pitch_q) + 32'(pxu * bpp_q[5:3]) : 32'd0;
      pixel_color_o <= color_q;
      last_o <= left_q == dda_pkg::CNT_W'(1);
    end
  end

  assign out_valid_o = out_valid_q;
endmodule
`default_nettype wire

@@ src/dda_chk.sv @@
// Port checker of the line rasterizer and its bind to the top level.
`default_nettype none
`include "dda_line_rasterizer_top_assert.svh"
module dda_chk (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic in_valid_i,
  input wire logic in_ready_i,
  input wire logic in_command_i,
  input wire logic out_valid_i,
  input wire logic out_ready_i
);
  `DDA_ASSERT_NEXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i)
  `DDA_ASSERT_SAME(a_no_take_when_blocked, out_valid_i && !out_ready_i, !in_ready_i)
  `DDA_ASSERT_SAME(a_pixel_from_step, $rose(out_valid_i),
                   $past(in_valid_i && in_ready_i && in_command_i))
  `DDA_ASSERT_NEXT(a_start_no_pixel, in_valid_i && in_ready_i && !in_command_i && !out_valid_i,
                   !out_valid_i)
endmodule

bind dda_line_rasterizer_top dda_chk u_chk (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (cmd_i.valid),
  .in_ready_i  (cmd_i.ready),
  .in_command_i(cmd_i.command),
  .out_valid_i (pix_o.valid),
  .out_ready_i (pix_o.ready)
);
`default_nettype wire
